// ===== hdl/ist_pkg.sv =====
// Shared types and constants for the interval set table.
package ist_pkg;

  localparam int MAX_RANGES = 16;
  localparam int VALUE_BITS = 64;
  localparam int FIELD_W    = 64;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int STEP_W     = $clog2(VALUE_BITS);

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_AND = 3'd2;
  localparam logic [2:0] KIND_SHD = 3'd3;
  localparam logic [2:0] KIND_SHU = 3'd4;
  localparam logic [2:0] KIND_FET = 3'd5;
  localparam logic [2:0] KIND_CLR = 3'd6;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FIELD_W-1:0] range_first;
    logic [FIELD_W-1:0] range_last;
    logic [FIELD_W-1:0] amount;
    logic [FIELD_W-1:0] center;
  } ist_in_t;

  typedef struct packed {
    logic               status;
    logic [4:0]         entry_count;
    logic [FIELD_W-1:0] span_first;
    logic [FIELD_W-1:0] span_last;
    logic [FIELD_W-1:0] total_length;
    logic [FIELD_W-1:0] chunk_first;
    logic [FIELD_W-1:0] chunk_last;
  } ist_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic fscan;
    logic fpick;
    logic fsel;
    logic flen;
    logic div_start;
    logic foff;
    logic fadj;
    logic ftail;
    logic ffin;
    logic latch;
  } ist_cmd_t;

  typedef struct packed {
    logic is_stream;
    logic is_fetch;
    logic fetch_zero;
    logic strm_done;
    logic scan_stop;
    logic need_div;
    logic div_busy;
  } ist_sts_t;

endpackage

// ===== hdl/ist_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module ist_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ist_pkg::VALUE_BITS-1:0] dividend_i,
  input  logic [ist_pkg::VALUE_BITS-1:0] divisor_i,
  output logic                           busy_o,
  output logic [ist_pkg::VALUE_BITS-1:0] rem_o
);

  logic                           busy_q, busy_d;
  logic [ist_pkg::STEP_W-1:0]     cnt_q, cnt_d;
  logic [ist_pkg::VALUE_BITS-1:0] quo_q, quo_d;
  logic [ist_pkg::VALUE_BITS-1:0] rem_q, rem_d;
  logic [ist_pkg::VALUE_BITS-1:0] dvs_q, dvs_d;
  logic [ist_pkg::VALUE_BITS:0]   trial;

  assign trial = {rem_q, quo_q[ist_pkg::VALUE_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ist_pkg::STEP_W'(ist_pkg::VALUE_BITS - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ist_pkg::VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = ist_pkg::VALUE_BITS'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[ist_pkg::VALUE_BITS-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/ist_dp.sv =====
// Datapath: ping-pong range table, streaming rewrite, fetch arithmetic, result word.
module ist_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ist_pkg::ist_cmd_t cmd_i,
  output ist_pkg::ist_sts_t sts_o,
  input  ist_pkg::ist_in_t  in_word_i,
  output ist_pkg::ist_out_t out_word_o
);

  localparam int VB = ist_pkg::VALUE_BITS;
  localparam logic [VB-1:0] VMASK = {VB{1'b1}};

  // two banks: current table and the one being rebuilt
  logic [VB-1:0] st_mem_q [0:1][0:ist_pkg::MAX_RANGES-1];
  logic [VB-1:0] en_mem_q [0:1][0:ist_pkg::MAX_RANGES-1];

  logic                    bank_q;
  logic [ist_pkg::CNT_W-1:0] cnt_q, rd_q, wr_q;
  logic [VB-1:0]           first_q, last_q, total_q;
  logic [2:0]              kind_q;
  logic [VB-1:0]           a_q, b_q, amt_q, c_q;
  logic                    empty_q;
  logic                    acc_live_q, split_q, ovf_q;
  logic [VB-1:0]           acc_s_q, acc_e_q;
  logic                    em_v_q;
  logic [VB-1:0]           em_s_q, em_e_q;
  logic [VB-1:0]           sum_s_q, sum_e_q, nfirst_q, nlast_q;
  logic                    have_prev_q, use_prev_q, remnz_q, tail_q;
  logic [VB-1:0]           pv_s_q, pv_e_q, nx_s_q, nx_e_q;
  logic [VB-1:0]           dnext_q, dprev_q, fs_q, fe_q, d_q, off_q, st_q;
  logic [VB-1:0]           cf_q, cl_q;
  ist_pkg::ist_out_t       res_q;

  logic [VB-1:0] s, e;
  logic          ent_v;
  logic          em_v, adv, acc_live_d, split_d;
  logic [VB-1:0] em_s, em_e, acc_s_d, acc_e_d;
  logic [VB:0]   up_s, up_e;
  logic [VB-1:0] sh_s, sh_e;
  logic          sh_gone;
  logic [VB-1:0] and_s, and_e;
  logic [VB-1:0] in_a, in_b, in_amt, in_ctr, half;
  logic [VB:0]   c_diff, adj_sum, tail_sum;
  logic          div_busy;
  logic [VB-1:0] div_rem;

  assign ent_v = (rd_q < cnt_q);
  assign s     = st_mem_q[bank_q][rd_q[ist_pkg::IDX_W-1:0]];
  assign e     = en_mem_q[bank_q][rd_q[ist_pkg::IDX_W-1:0]];

  // saturating shift of one entry
  always_comb begin
    up_s = {1'b0, s} + {1'b0, amt_q};
    up_e = {1'b0, e} + {1'b0, amt_q};
    if (kind_q == ist_pkg::KIND_SHU) begin
      sh_s    = (up_s >= {1'b0, VMASK}) ? VMASK : up_s[VB-1:0];
      sh_e    = (up_e >= {1'b0, VMASK}) ? VMASK : up_e[VB-1:0];
      sh_gone = (sh_s == VMASK) && (sh_e == VMASK);
    end else begin
      sh_s    = (s < amt_q) ? '0 : s - amt_q;
      sh_e    = (e < amt_q) ? '0 : e - amt_q;
      sh_gone = (sh_s == '0) && (sh_e == '0);
    end
  end

  assign and_s = (s > a_q) ? s : a_q;
  assign and_e = (e < b_q) ? e : b_q;

  // one entry of the streaming rewrite per step
  always_comb begin
    em_v       = 1'b0;
    em_s       = s;
    em_e       = e;
    adv        = 1'b0;
    acc_live_d = acc_live_q;
    acc_s_d    = acc_s_q;
    acc_e_d    = acc_e_q;
    split_d    = split_q;
    case (kind_q)
      ist_pkg::KIND_ADD: begin
        if (!ent_v) begin
          if (acc_live_q) begin
            em_v = 1'b1; em_s = acc_s_q; em_e = acc_e_q; acc_live_d = 1'b0;
          end
        end else if (e < a_q) begin
          em_v = 1'b1; adv = 1'b1;
        end else if (acc_live_q) begin
          if (s <= b_q) begin
            acc_s_d = (s < acc_s_q) ? s : acc_s_q;
            acc_e_d = (e > acc_e_q) ? e : acc_e_q;
            adv     = 1'b1;
          end else begin
            em_v = 1'b1; em_s = acc_s_q; em_e = acc_e_q; acc_live_d = 1'b0;
          end
        end else begin
          em_v = 1'b1; adv = 1'b1;
        end
      end
      ist_pkg::KIND_SUB: begin
        if (ent_v) begin
          if (empty_q || e < a_q || s > b_q) begin
            em_v = 1'b1; adv = 1'b1;
          end else if (split_q) begin
            em_v = 1'b1; em_s = b_q; adv = 1'b1; split_d = 1'b0;
          end else if (s >= a_q && e > b_q) begin
            em_v = 1'b1; em_s = b_q; adv = 1'b1;
          end else if (s < a_q && e <= b_q) begin
            em_v = 1'b1; em_e = a_q; adv = 1'b1;
          end else if (s >= a_q) begin
            adv = 1'b1;
          end else begin
            // operand strictly inside: left piece now, right piece next step
            em_v = 1'b1; em_e = a_q; split_d = 1'b1;
          end
        end
      end
      ist_pkg::KIND_AND, ist_pkg::KIND_CLR: begin
        if (ent_v) begin
          adv = 1'b1;
          if (kind_q == ist_pkg::KIND_AND && !empty_q && and_s < and_e) begin
            em_v = 1'b1; em_s = and_s; em_e = and_e;
          end
        end
      end
      ist_pkg::KIND_SHD, ist_pkg::KIND_SHU: begin
        if (ent_v) begin
          adv  = 1'b1;
          em_v = !sh_gone;
          em_s = sh_s;
          em_e = sh_e;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_a   = VB'(in_word_i.range_first);
  assign in_b   = VB'(in_word_i.range_last);
  assign in_amt = VB'(in_word_i.amount);
  assign in_ctr = VB'(in_word_i.center);
  assign half   = in_amt >> 1;
  assign c_diff = {1'b0, in_ctr} - {1'b0, half};

  assign adj_sum  = {1'b0, off_q} + {1'b0, amt_q};
  assign tail_sum = {1'b0, fs_q} + {1'b0, off_q};

  ist_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (d_q),
    .divisor_i  (amt_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= 1'b0;
      cnt_q      <= '0;
      first_q    <= '0;
      last_q     <= '0;
      total_q    <= '0;
      kind_q     <= ist_pkg::KIND_CLR;
      rd_q       <= '0;
      wr_q       <= '0;
      acc_live_q <= 1'b0;
      split_q    <= 1'b0;
      ovf_q      <= 1'b0;
      em_v_q     <= 1'b0;
    end else begin
      em_v_q <= cmd_i.step & em_v;
      if (cmd_i.load) begin
        kind_q     <= in_word_i.kind;
        rd_q       <= '0;
        wr_q       <= '0;
        acc_live_q <= (in_word_i.kind == ist_pkg::KIND_ADD) && (in_b > in_a);
        split_q    <= 1'b0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.step) begin
        acc_live_q <= acc_live_d;
        split_q    <= split_d;
        if (adv) begin
          rd_q <= rd_q + 1'b1;
        end
      end
      if (cmd_i.fscan && ent_v && s <= c_q) begin
        rd_q <= rd_q + 1'b1;
      end
      if (em_v_q) begin
        if (wr_q == ist_pkg::CNT_W'(ist_pkg::MAX_RANGES)) begin
          ovf_q <= 1'b1;
        end else begin
          wr_q <= wr_q + 1'b1;
        end
      end
      if (cmd_i.commit && !ovf_q) begin
        bank_q  <= ~bank_q;
        cnt_q   <= wr_q;
        first_q <= nfirst_q;
        last_q  <= nlast_q;
        total_q <= sum_e_q - sum_s_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q         <= in_a;
      b_q         <= in_b;
      amt_q       <= in_amt;
      c_q         <= c_diff[VB] ? '0 : c_diff[VB-1:0];
      empty_q     <= (in_b <= in_a);
      acc_s_q     <= in_a;
      acc_e_q     <= in_b;
      sum_s_q     <= '0;
      sum_e_q     <= '0;
      have_prev_q <= 1'b0;
      cf_q        <= '0;
      cl_q        <= '0;
    end
    if (cmd_i.step) begin
      acc_s_q <= acc_s_d;
      acc_e_q <= acc_e_d;
      em_s_q  <= em_s;
      em_e_q  <= em_e;
    end
    if (em_v_q && wr_q != ist_pkg::CNT_W'(ist_pkg::MAX_RANGES)) begin
      st_mem_q[~bank_q][wr_q[ist_pkg::IDX_W-1:0]] <= em_s_q;
      en_mem_q[~bank_q][wr_q[ist_pkg::IDX_W-1:0]] <= em_e_q;
      sum_s_q <= sum_s_q + em_s_q;
      sum_e_q <= sum_e_q + em_e_q;
      nlast_q <= em_e_q;
      if (wr_q == '0) begin
        nfirst_q <= em_s_q;
      end
    end
    if (cmd_i.fscan && ent_v && s <= c_q) begin
      pv_s_q      <= s;
      pv_e_q      <= e;
      have_prev_q <= 1'b1;
    end
    if (cmd_i.fpick) begin
      nx_s_q  <= s;
      nx_e_q  <= e;
      dnext_q <= ent_v ? s - c_q : VMASK;
      dprev_q <= have_prev_q ? ((pv_e_q < c_q) ? c_q - pv_e_q : '0) : VMASK;
    end
    if (cmd_i.fsel) begin
      use_prev_q <= !(dnext_q <= dprev_q);
      fs_q       <= (dnext_q <= dprev_q) ? nx_s_q : pv_s_q;
      fe_q       <= (dnext_q <= dprev_q) ? nx_e_q : pv_e_q;
    end
    if (cmd_i.flen) begin
      d_q <= c_q - fs_q;
      if (fe_q - fs_q < amt_q) begin
        cf_q <= fs_q;
        cl_q <= fe_q;
      end else if (!use_prev_q) begin
        cf_q <= fs_q;
        cl_q <= fs_q + amt_q;
      end
    end
    if (cmd_i.foff) begin
      off_q   <= d_q - div_rem;   // floor(d / amount) * amount
      remnz_q <= (div_rem != '0);
      tail_q  <= 1'b0;
    end
    if (cmd_i.fadj && remnz_q) begin
      if (adj_sum > {1'b0, VMASK}) begin
        tail_q <= 1'b1;
      end else begin
        off_q <= adj_sum[VB-1:0];
      end
    end
    if (cmd_i.ftail) begin
      st_q <= tail_sum[VB-1:0];
      if (tail_sum > {1'b0, VMASK}) begin
        tail_q <= 1'b1;
      end
    end
    if (cmd_i.ffin) begin
      if (tail_q || fe_q <= st_q) begin
        cf_q <= fe_q - amt_q;
        cl_q <= fe_q;
      end else begin
        cf_q <= st_q;
        cl_q <= (amt_q >= fe_q - st_q) ? fe_q : st_q + amt_q;
      end
    end
    if (cmd_i.latch) begin
      res_q.status       <= ovf_q;
      res_q.entry_count  <= 5'(cnt_q);
      res_q.span_first   <= (cnt_q == '0) ? '0 : ist_pkg::FIELD_W'(first_q);
      res_q.span_last    <= (cnt_q == '0) ? '0 : ist_pkg::FIELD_W'(last_q);
      res_q.total_length <= ist_pkg::FIELD_W'(total_q);
      res_q.chunk_first  <= ist_pkg::FIELD_W'(cf_q);
      res_q.chunk_last   <= ist_pkg::FIELD_W'(cl_q);
    end
  end

  assign sts_o.is_stream  = kind_q inside {ist_pkg::KIND_ADD, ist_pkg::KIND_SUB,
                                           ist_pkg::KIND_AND, ist_pkg::KIND_SHD,
                                           ist_pkg::KIND_SHU, ist_pkg::KIND_CLR};
  assign sts_o.is_fetch   = (kind_q == ist_pkg::KIND_FET);
  assign sts_o.fetch_zero = (cnt_q == '0) || (amt_q == '0);
  assign sts_o.strm_done  = !ent_v && !acc_live_q && !split_q;
  assign sts_o.scan_stop  = !(ent_v && s <= c_q);
  assign sts_o.need_div   = use_prev_q && !(fe_q - fs_q < amt_q);
  assign sts_o.div_busy   = div_busy;

  assign out_word_o = res_q;

endmodule

// ===== hdl/ist_ctrl.sv =====
// Request sequencer: steps the datapath through each request kind.
module ist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ist_pkg::ist_sts_t sts_i,
  output ist_pkg::ist_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_STRM   = 4'd2;
  localparam logic [3:0] S_COMMIT = 4'd3;
  localparam logic [3:0] S_FSCAN  = 4'd4;
  localparam logic [3:0] S_FPICK  = 4'd5;
  localparam logic [3:0] S_FSEL   = 4'd6;
  localparam logic [3:0] S_FLEN   = 4'd7;
  localparam logic [3:0] S_FDIV   = 4'd8;
  localparam logic [3:0] S_FWAIT  = 4'd9;
  localparam logic [3:0] S_FOFF   = 4'd10;
  localparam logic [3:0] S_FADJ   = 4'd11;
  localparam logic [3:0] S_FTAIL  = 4'd12;
  localparam logic [3:0] S_FFIN   = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_latch;

  assign can_latch = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_stream) begin
          state_d = S_STRM;
        end else if (sts_i.is_fetch && !sts_i.fetch_zero) begin
          state_d = S_FSCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_STRM: begin
        if (sts_i.strm_done) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_FSCAN: begin
        if (sts_i.scan_stop) begin
          state_d = S_FPICK;
        end else begin
          cmd_o.fscan = 1'b1;
        end
      end
      S_FPICK: begin
        cmd_o.fpick = 1'b1;
        state_d     = S_FSEL;
      end
      S_FSEL: begin
        cmd_o.fsel = 1'b1;
        state_d    = S_FLEN;
      end
      S_FLEN: begin
        cmd_o.flen = 1'b1;
        state_d    = sts_i.need_div ? S_FDIV : S_OUT;
      end
      S_FDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_FWAIT;
      end
      S_FWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_FOFF;
        end
      end
      S_FOFF: begin
        cmd_o.foff = 1'b1;
        state_d    = S_FADJ;
      end
      S_FADJ: begin
        cmd_o.fadj = 1'b1;
        state_d    = S_FTAIL;
      end
      S_FTAIL: begin
        cmd_o.ftail = 1'b1;
        state_d     = S_FFIN;
      end
      S_FFIN: begin
        cmd_o.ffin = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (can_latch) begin
          cmd_o.latch = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.latch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/interval_set_table_top.sv =====
// Top level of the interval set table: sequencer plus datapath.
// Add/subtract/intersect/shift/clear stream once through the entries held, then commit
//   the rebuilt bank unless it overflowed, and latch the result word.
// Fetch may also run the remainder unit, and waits while it is busy.
// Throughput: one request in flight; the next word is taken while a result waits.
// Reset clears the entry count and handshake state; table storage is not cleared.
module interval_set_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ist_pkg::ist_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ist_pkg::ist_out_t out_word_o
);

  // command and status buses between sequencer and datapath
  ist_pkg::ist_cmd_t cmd;
  ist_pkg::ist_sts_t sts;

  // sequencer owns both handshakes; the result word sits in the datapath's
  // output register, so a new request word can be taken while it waits
  ist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: table banks are rebuilt one entry per cycle, then swapped;
  // an overflowing rebuild is simply not swapped in
  ist_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== hdl/ist_chk.sv =====
// Port-level checker for the interval set table, bound to the top level.
module ist_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ist_pkg::ist_out_t out_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |->
      out_word_o.entry_count == 5'(ist_pkg::MAX_RANGES))
    else $error("reject reported with table not full");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.entry_count <= 5'(ist_pkg::MAX_RANGES))
    else $error("entry count above capacity");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.entry_count == '0 |->
      out_word_o.span_first == '0 && out_word_o.span_last == '0 &&
      out_word_o.total_length == '0)
    else $error("empty table with nonzero span or length");

  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.chunk_first <= out_word_o.chunk_last)
    else $error("chunk start past chunk end");

endmodule

bind interval_set_table_top ist_chk u_ist_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the interval set table: random and directed requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] val_t;
  localparam val_t VMAX = '1;
  localparam logic [2:0] KIND_NOP = 3'd7;
  localparam int LIMIT_CYCLES = 1500000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  ist_pkg::ist_in_t  in_word_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  ist_pkg::ist_out_t out_word_o;

  interval_set_table_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table.
  val_t      shd_start [ist_pkg::MAX_RANGES+1];
  val_t      shd_end   [ist_pkg::MAX_RANGES+1];
  int unsigned shd_cnt;

  ist_pkg::ist_in_t   pending_words[$];
  ist_pkg::ist_out_t  expected_words[$];
  int        mismatches;
  int        src_idle_pct;
  int        snk_stall_pct;
  bit        hold_src;
  int unsigned cycle_cnt;

  function automatic void add_pending(ist_pkg::ist_in_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void ins_at(int unsigned pos, val_t s, val_t e);
    for (int unsigned k = shd_cnt; k > pos; k--) begin
      shd_start[k] = shd_start[k-1];
      shd_end[k]   = shd_end[k-1];
    end
    shd_start[pos] = s;
    shd_end[pos]   = e;
    shd_cnt++;
  endfunction

  function automatic void del_at(int unsigned pos, int unsigned n);
    for (int unsigned k = pos; k + n < shd_cnt; k++) begin
      shd_start[k] = shd_start[k+n];
      shd_end[k]   = shd_end[k+n];
    end
    shd_cnt -= n;
  endfunction

  function automatic int unsigned first_hit(val_t a);
    int unsigned i;
    i = 0;
    while (i < shd_cnt && shd_end[i] < a) i++;
    return i;
  endfunction

  function automatic bit add_range(val_t a, val_t b);
    int unsigned i, j;
    val_t s, e;
    if (b <= a) return 1'b0;
    i = first_hit(a);
    if (i == shd_cnt || shd_start[i] > b) begin
      if (shd_cnt >= ist_pkg::MAX_RANGES) return 1'b1;
      ins_at(i, a, b);
      return 1'b0;
    end
    j = i;
    while (j < shd_cnt && shd_start[j] <= b) j++;
    s = shd_start[i] < a ? shd_start[i] : a;
    e = shd_end[j-1] > b ? shd_end[j-1] : b;
    shd_start[i] = s;
    shd_end[i]   = e;
    del_at(i + 1, j - i - 1);
    return 1'b0;
  endfunction

  function automatic bit sub_range(val_t a, val_t b);
    int unsigned i;
    val_t s, e;
    if (b <= a) return 1'b0;
    i = first_hit(a);
    if (i < shd_cnt && shd_start[i] < a && shd_end[i] > b &&
        shd_cnt >= ist_pkg::MAX_RANGES)
      return 1'b1;
    while (i < shd_cnt && shd_start[i] <= b) begin
      s = shd_start[i];
      e = shd_end[i];
      if (s >= a && e > b) begin
        shd_start[i] = b;
        i++;
      end else if (s < a && e <= b) begin
        shd_end[i] = a;
        i++;
      end else if (s >= a && e <= b) begin
        del_at(i, 1);
      end else begin
        shd_end[i] = a;
        ins_at(i + 1, b, e);
        i += 2;
      end
    end
    return 1'b0;
  endfunction

  function automatic void clip_range(val_t a, val_t b);
    int unsigned w;
    val_t s, e;
    w = 0;
    if (b <= a) begin
      shd_cnt = 0;
      return;
    end
    for (int unsigned i = first_hit(a); i < shd_cnt && shd_start[i] <= b; i++) begin
      s = shd_start[i] > a ? shd_start[i] : a;
      e = shd_end[i] < b ? shd_end[i] : b;
      if (s < e) begin
        shd_start[w] = s;
        shd_end[w]   = e;
        w++;
      end
    end
    shd_cnt = w;
  endfunction

  function automatic void shift_ranges(val_t d, bit up);
    int unsigned w;
    val_t s, e;
    bit gone;
    w = 0;
    for (int unsigned i = 0; i < shd_cnt; i++) begin
      s = shd_start[i];
      e = shd_end[i];
      if (up) begin
        s = (VMAX - d <= s) ? VMAX : s + d;
        e = (VMAX - d <= e) ? VMAX : e + d;
        gone = (s == VMAX && e == VMAX);
      end else begin
        s = (s < d) ? '0 : s - d;
        e = (e < d) ? '0 : e - d;
        gone = (s == 0 && e == 0);
      end
      if (!gone) begin
        shd_start[w] = s;
        shd_end[w]   = e;
        w++;
      end
    end
    shd_cnt = w;
  endfunction

  function automatic void fetch_chunk(val_t dt, val_t ctr, output val_t cf, output val_t cl);
    val_t c, dnext, dprev, fs, fe, d, off, st;
    int unsigned i;
    bit tail;
    cf = '0;
    cl = '0;
    dnext = VMAX;
    dprev = VMAX;
    tail = 1'b0;
    if (shd_cnt == 0 || dt == 0) return;
    c = (ctr < dt / 2) ? '0 : ctr - dt / 2;
    i = 0;
    while (i < shd_cnt && shd_start[i] <= c) i++;
    if (i < shd_cnt) dnext = shd_start[i] - c;
    if (i > 0) dprev = (shd_end[i-1] < c) ? c - shd_end[i-1] : '0;
    if (dnext <= dprev) begin
      fs = shd_start[i];
      fe = shd_end[i];
      cf = fs;
      cl = (fe - fs < dt) ? fe : fs + dt;
      return;
    end
    fs = shd_start[i-1];
    fe = shd_end[i-1];
    if (fe - fs < dt) begin
      cf = fs;
      cl = fe;
      return;
    end
    d = c - fs;
    off = (d / dt) * dt;
    if (d % dt != 0) begin
      if (dt > VMAX - off) tail = 1'b1;
      else off += dt;
    end
    if (!tail && off > VMAX - fs) tail = 1'b1;
    st = tail ? '0 : fs + off;
    if (tail || fe <= st) begin
      cf = fe - dt;
      cl = fe;
      return;
    end
    cf = st;
    cl = (dt >= fe - st) ? fe : st + dt;
  endfunction

  // Apply one request to the shadow table and return the result word.
  function automatic ist_pkg::ist_out_t table_result(ist_pkg::ist_in_t w);
    ist_pkg::ist_out_t r;
    val_t cf, cl, tot;
    r = '0;
    cf = '0;
    cl = '0;
    tot = '0;
    case (w.kind)
      ist_pkg::KIND_ADD: r.status = add_range(w.range_first, w.range_last);
      ist_pkg::KIND_SUB: r.status = sub_range(w.range_first, w.range_last);
      ist_pkg::KIND_AND: clip_range(w.range_first, w.range_last);
      ist_pkg::KIND_SHD: shift_ranges(w.amount, 1'b0);
      ist_pkg::KIND_SHU: shift_ranges(w.amount, 1'b1);
      ist_pkg::KIND_FET: fetch_chunk(w.amount, w.center, cf, cl);
      ist_pkg::KIND_CLR: shd_cnt = 0;
      default: ;
    endcase
    for (int unsigned i = 0; i < shd_cnt; i++) tot += shd_end[i] - shd_start[i];
    r.entry_count  = shd_cnt[4:0];
    r.span_first   = shd_cnt ? shd_start[0] : '0;
    r.span_last    = shd_cnt ? shd_end[shd_cnt-1] : '0;
    r.total_length = tot;
    r.chunk_first  = cf;
    r.chunk_last   = cl;
    return r;
  endfunction

  function automatic ist_pkg::ist_in_t mk_word(logic [2:0] k, val_t a, val_t b,
                                               val_t amt, val_t ctr);
    ist_pkg::ist_in_t w;
    w.kind = k;
    w.range_first = a;
    w.range_last = b;
    w.amount = amt;
    w.center = ctr;
    return w;
  endfunction

  function automatic val_t rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Values mostly from a narrow window so ranges overlap, touch and split often;
  // sometimes near either end of the value space, sometimes anywhere.
  function automatic val_t rnd_point(val_t base);
    case ($urandom_range(9))
      0: return rnd64();
      1: return VMAX - $urandom_range(300);
      2: return val_t'($urandom_range(300));
      default: return base + $urandom_range(1000);
    endcase
  endfunction

  function automatic ist_pkg::ist_in_t rnd_word(val_t base);
    val_t a, b, amt;
    logic [2:0] k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 34) k = ist_pkg::KIND_ADD;
    else if (sel < 56) k = ist_pkg::KIND_SUB;
    else if (sel < 62) k = ist_pkg::KIND_AND;
    else if (sel < 70) k = ist_pkg::KIND_SHD;
    else if (sel < 78) k = ist_pkg::KIND_SHU;
    else if (sel < 95) k = ist_pkg::KIND_FET;
    else if (sel < 98) k = ist_pkg::KIND_CLR;
    else k = KIND_NOP;
    a = rnd_point(base);
    if ($urandom_range(9) == 0) b = rnd_point(base);
    else b = a + $urandom_range(150);
    case ($urandom_range(5))
      0: amt = rnd64();
      1: amt = '0;
      2: amt = rnd64() >> $urandom_range(63);
      default: amt = val_t'($urandom_range(200));
    endcase
    return mk_word(k, a, b, amt, rnd_point(base));
  endfunction

  // Driver: next word from the pending queue, valid held until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && !hold_src &&
            $urandom_range(99) >= src_idle_pct) begin
          in_word_i  <= pending_words[0];
          in_valid_i <= 1'b1;
          expected_words = {expected_words, table_result(pending_words[0])};
          void'(pending_words.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_word_o);
        end else begin
          if (out_word_o !== expected_words[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_words[0], out_word_o);
          end
          void'(expected_words.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int idle, int stall, int n);
    val_t base;
    src_idle_pct = idle;
    snk_stall_pct = stall;
    base = rnd64();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) base = rnd64();
      add_pending(rnd_word(base));
    end
    drain();
  endtask

  initial begin
    val_t lo;
    mismatches = 0;
    cycle_cnt = 0;
    hold_src = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    shd_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-table cases, field extremes, every kind.
    add_pending(mk_word(ist_pkg::KIND_FET, '0, '0, 64'd10, 64'd5));
    add_pending(mk_word(ist_pkg::KIND_ADD, 64'd100, 64'd50, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_ADD, '0, VMAX, VMAX, VMAX));
    add_pending(mk_word(ist_pkg::KIND_FET, '0, '0, '0, 64'd7));
    add_pending(mk_word(ist_pkg::KIND_FET, '0, '0, VMAX, VMAX));
    add_pending(mk_word(ist_pkg::KIND_FET, '0, '0, 64'd1000, VMAX));
    add_pending(mk_word(ist_pkg::KIND_SUB, 64'd10, 64'd20, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_SUB, 64'd30, 64'd25, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_SHU, '0, '0, 64'd5, '0));
    add_pending(mk_word(ist_pkg::KIND_SHD, '0, '0, VMAX - 64'd3, '0));
    add_pending(mk_word(KIND_NOP, VMAX, VMAX, VMAX, VMAX));
    add_pending(mk_word(ist_pkg::KIND_ADD, VMAX - 64'd9, VMAX, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_SHU, '0, '0, VMAX, '0));
    add_pending(mk_word(ist_pkg::KIND_AND, 64'd5, 64'd5, '0, '0));
    // Fill to capacity, then overflow on add and on split.
    for (int i = 0; i < 16; i++)
      add_pending(mk_word(ist_pkg::KIND_ADD, val_t'(i * 10), val_t'(i * 10 + 5), '0, '0));
    add_pending(mk_word(ist_pkg::KIND_ADD, 64'd200, 64'd300, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_SUB, 64'd1, 64'd2, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_FET, '0, '0, 64'd3, 64'd77));
    add_pending(mk_word(ist_pkg::KIND_AND, 64'd12, 64'd143, '0, '0));
    add_pending(mk_word(ist_pkg::KIND_CLR, '0, '0, '0, '0));
    drain();

    // Sender is held off with words already queued, then released.
    hold_src = 1;
    lo = 64'd1000;
    for (int i = 0; i < 4; i++)
      add_pending(mk_word(ist_pkg::KIND_ADD, lo + i * 7, lo + i * 7 + 3, '0, '0));
    repeat (20) @(posedge clk_i);
    hold_src = 0;
    drain();

    run_phase(0, 0, 140);
    run_phase(82, 0, 130);
    run_phase(0, 82, 130);
    run_phase(28, 28, 130);

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ist_pkg.sv
hdl/ist_div.sv
hdl/ist_dp.sv
hdl/ist_ctrl.sv
hdl/interval_set_table_top.sv
hdl/ist_chk.sv
tb/tb.sv
